/* hw/rtl/hdbu_pkg.sv */
// ----------------------------------------------------------------------------
// hdbu_pkg: shared definitions for the half-duplex bit UART
// Item kinds, receive bit position codes and transmit framing constants.
// ----------------------------------------------------------------------------
package hdbu_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_SEND       = 3'd1,
    KIND_POP        = 3'd2,
    KIND_PURGE      = 3'd3,
    KIND_LISTEN_ON  = 3'd4,
    KIND_LISTEN_OFF = 3'd5
  } kind_e;

  // Receive bit position: 0 to 7 are data bits, 8 awaits the stop bit.
  localparam logic [3:0] RX_WAIT_START = 4'd15;
  localparam logic [3:0] RX_AWAIT_STOP = 4'd8;

  // Transmit shift word: start bit in bit 0, stop bit in bit 9.
  localparam int unsigned TX_FRAME_W = 10;
  localparam logic [TX_FRAME_W-1:0] FRAME_STOP = 10'h200;

endpackage

/* hw/rtl/hdbu_ram.sv */
// ----------------------------------------------------------------------------
// hdbu_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hdbu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/half_duplex_bit_uart_unit.sv */
// ----------------------------------------------------------------------------
// half_duplex_bit_uart_unit: single-wire half-duplex 8N1 UART
// Transmit framing and shifting, receive sampling and a receive ring FIFO,
// advanced one input beat at a time.
// ----------------------------------------------------------------------------
// Usage: every input beat is one command. A tick beat advances the transmit
// shifter by one bit period and, while listening, samples line_in_i. Other
// beats load a byte to send, pop a received byte, purge the receive FIFO,
// or turn listening on and off. Each accepted beat produces exactly one
// result beat that reports the wire level, driver enable, busy, command
// status, popped byte, sticky overflow and the listening tick count.
// Throughput is one beat per cycle while the output is not stalled. The
// registered result appears in the cycle after the input beat is accepted,
// with the registered FIFO read data. The FIFO holds FIFO_DEPTH-1 bytes.
// A finished result waits in the output register; while the receiver
// stalls it, the output beat holds and the input side stalls, so no beat
// is lost. A new input beat is taken in the same cycle that the output
// register is emptied. Reset puts the wire idle high with the driver on,
// listening off, the FIFO empty and the flags cleared; no clearing pass is
// needed because only written FIFO entries are ever read.
// ----------------------------------------------------------------------------
module half_duplex_bit_uart_unit #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic       line_in_i,
  input  logic [7:0] tx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       line_out_o,
  output logic       line_drive_o,
  output logic       tx_busy_o,
  output logic       cmd_ok_o,
  output logic       rx_valid_o,
  output logic [7:0] rx_data_o,
  output logic       overflow_o,
  output logic [7:0] tick_count_o
);

  import hdbu_pkg::*;

  localparam int unsigned ADDR_W = $clog2(FIFO_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FIFO_DEPTH - 1);

  // UART state.
  logic [TX_FRAME_W-1:0] tx_shift_q, tx_shift_d;
  logic                  tx_active_q, tx_active_d;
  logic                  wire_q, wire_d;
  logic                  drive_q, drive_d;
  logic                  listening_q, listening_d;
  logic [3:0]            rx_pos_q, rx_pos_d;
  logic [7:0]            rx_shift_q, rx_shift_d;
  logic [ADDR_W-1:0]     head_q, head_d;
  logic [ADDR_W-1:0]     tail_q, tail_d;
  logic                  ovf_q, ovf_d;
  logic [7:0]            ticks_q, ticks_d;

  // Output register.
  logic       out_valid_q;
  logic       res_wire_q, res_drive_q, res_busy_q, res_ok_q;
  logic       res_valid_q, res_ovf_q;
  logic [7:0] res_ticks_q;

  logic              in_accept;
  kind_e             kind;
  logic              cmd_ok;
  logic              push;
  logic              pop;
  logic [ADDR_W-1:0] head_next;
  logic [ADDR_W-1:0] tail_next;
  logic [7:0]        ram_rdata;

  // The input side is free whenever the output register is empty or is
  // being emptied in this cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign kind       = kind_e'(kind_i);

  // Ring pointers wrap at the configured depth, which need not be a power
  // of two.
  assign head_next = (head_q == LAST_ADDR) ? '0 : head_q + ADDR_W'(1);
  assign tail_next = (tail_q == LAST_ADDR) ? '0 : tail_q + ADDR_W'(1);

  always_comb begin
    tx_shift_d  = tx_shift_q;
    tx_active_d = tx_active_q;
    wire_d      = wire_q;
    drive_d     = drive_q;
    listening_d = listening_q;
    rx_pos_d    = rx_pos_q;
    rx_shift_d  = rx_shift_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ovf_d       = ovf_q;
    ticks_d     = ticks_q;
    cmd_ok      = 1'b1;
    push        = 1'b0;
    pop         = 1'b0;
    if (in_accept) begin
      case (kind)
        KIND_TICK: begin
          // Busy drops on the first tick after the last bit has gone out.
          if (tx_active_q) begin
            if (tx_shift_q != '0) begin
              wire_d     = tx_shift_q[0];
              tx_shift_d = {1'b0, tx_shift_q[TX_FRAME_W-1:1]};
            end else begin
              tx_active_d = 1'b0;
            end
          end
          if (listening_q) begin
            ticks_d = ticks_q + 8'd1;
            if (rx_pos_q == RX_WAIT_START) begin
              if (!line_in_i) begin
                rx_pos_d   = '0;
                rx_shift_d = '0;
              end
            end else if (rx_pos_q >= RX_AWAIT_STOP) begin
              // A low stop bit drops the byte silently.
              if (line_in_i) begin
                if (head_next != tail_q) begin
                  push   = 1'b1;
                  head_d = head_next;
                end else begin
                  ovf_d = 1'b1;
                end
              end
              rx_pos_d = RX_WAIT_START;
            end else begin
              rx_shift_d = {line_in_i, rx_shift_q[7:1]};
              rx_pos_d   = rx_pos_q + 4'd1;
            end
          end
        end
        KIND_SEND: begin
          if (tx_active_q) begin
            cmd_ok = 1'b0;
          end else begin
            tx_shift_d  = FRAME_STOP | {1'b0, tx_byte_i, 1'b0};
            tx_active_d = 1'b1;
            drive_d     = 1'b1;
          end
        end
        KIND_POP: begin
          if (head_q != tail_q) begin
            pop    = 1'b1;
            tail_d = tail_next;
          end
        end
        KIND_PURGE: begin
          head_d = '0;
          tail_d = '0;
        end
        KIND_LISTEN_ON: begin
          listening_d = 1'b1;
          drive_d     = 1'b0;
          rx_pos_d    = RX_WAIT_START;
        end
        KIND_LISTEN_OFF: begin
          listening_d = 1'b0;
          drive_d     = 1'b1;
          rx_pos_d    = RX_WAIT_START;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_shift_q  <= '0;
      tx_active_q <= 1'b0;
      wire_q      <= 1'b1;
      drive_q     <= 1'b1;
      listening_q <= 1'b0;
      rx_pos_q    <= RX_WAIT_START;
      rx_shift_q  <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      ovf_q       <= 1'b0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tx_shift_q  <= tx_shift_d;
      tx_active_q <= tx_active_d;
      wire_q      <= wire_d;
      drive_q     <= drive_d;
      listening_q <= listening_d;
      rx_pos_q    <= rx_pos_d;
      rx_shift_q  <= rx_shift_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      ovf_q       <= ovf_d;
      ticks_q     <= ticks_d;
      out_valid_q <= in_accept | (out_valid_q & out_stall_i);
    end
  end

  // Result fields are the state after the update.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_wire_q  <= wire_d;
      res_drive_q <= drive_d;
      res_busy_q  <= tx_active_d;
      res_ok_q    <= cmd_ok;
      res_valid_q <= pop;
      res_ovf_q   <= ovf_d;
      res_ticks_q <= ticks_d;
    end
  end

  // The memory is read only when a pop enters the output register, so its
  // read data stays with that beat for as long as the beat is stalled.
  hdbu_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_rx_fifo (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (head_q),
    .wdata_i (rx_shift_q),
    .re_i    (pop),
    .raddr_i (tail_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign line_out_o   = res_wire_q;
  assign line_drive_o = res_drive_q;
  assign tx_busy_o    = res_busy_q;
  assign cmd_ok_o     = res_ok_q;
  assign rx_valid_o   = res_valid_q;
  assign rx_data_o    = res_valid_q ? ram_rdata : 8'd0;
  assign overflow_o   = res_ovf_q;
  assign tick_count_o = res_ticks_q;

  // The receive position only takes data, stop-wait or start-wait codes.
  a_rx_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_pos_q <= RX_AWAIT_STOP) || (rx_pos_q == RX_WAIT_START))
    else $error("receive bit position out of range");

  // Once set, the overflow flag stays set until reset.
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared without reset");

  // A refused send leaves the transmit word untouched.
  a_refused_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (kind == KIND_SEND) && tx_active_q) |=> $stable(tx_shift_q))
    else $error("refused send changed the transmit word");

  // Busy only drops on a tick, after the word has emptied.
  a_busy_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(tx_active_q) |-> $past(in_accept && (kind == KIND_TICK) &&
                                 (tx_shift_q == '0)))
    else $error("transmit busy dropped outside an empty-word tick");

  // A push never makes the FIFO look empty.
  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (head_q != tail_q))
    else $error("push left the FIFO empty");

endmodule

/* dv/tb_half_duplex_bit_uart_unit.sv */
// ----------------------------------------------------------------------------
// tb_half_duplex_bit_uart_unit: self-checking bench for the half-duplex UART
// Drives command beats (ticks, sends, pops, purges, listen on and off) through
// the valid/stall input channel. A behavioral copy of the UART state predicts
// every result beat, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_half_duplex_bit_uart_unit;
  import hdbu_pkg::*;

  localparam int unsigned BUF_DEPTH = 32;
  // Kind codes the block decodes as no-ops.
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;
  // Cycles without any accepted beat before the run is declared hung. Even a
  // 63 percent random stall on one side keeps every correct quiet stretch
  // many times shorter than this.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  // One result beat, in the order of the output ports.
  typedef struct packed {
    logic       line_out;
    logic       drive;
    logic       busy;
    logic       ok;
    logic       rx_vld;
    logic [7:0] rx_byte;
    logic       ovf;
    logic [7:0] ticks;
  } uart_status_t;

  // Clock, reset and every block input start at a known level.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [2:0] kind_i      = KIND_TICK;
  logic       line_in_i   = 1'b1;
  logic [7:0] tx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic       line_out_o;
  logic       line_drive_o;
  logic       tx_busy_o;
  logic       cmd_ok_o;
  logic       rx_valid_o;
  logic [7:0] rx_data_o;
  logic       overflow_o;
  logic [7:0] tick_count_o;

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;

  // Results predicted for accepted command beats, oldest first.
  uart_status_t status_q[$];

  // Behavioral UART state, starting from its reset values.
  logic [TX_FRAME_W-1:0] u_tx_word  = '0;
  logic                  u_tx_on    = 1'b0;
  logic                  u_wire     = 1'b1;
  logic                  u_drive    = 1'b1;
  logic                  u_listen   = 1'b0;
  logic [3:0]            u_rx_pos   = RX_WAIT_START;
  logic [7:0]            u_rx_sr    = '0;
  logic [7:0]            u_fifo[BUF_DEPTH];
  int unsigned           u_head     = 0;
  int unsigned           u_tail     = 0;
  logic                  u_ovf      = 1'b0;
  logic [7:0]            u_ticks    = '0;

  always #6 clk_i = ~clk_i;

  half_duplex_bit_uart_unit #(
    .FIFO_DEPTH(BUF_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .line_in_i   (line_in_i),
    .tx_byte_i   (tx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .line_out_o  (line_out_o),
    .line_drive_o(line_drive_o),
    .tx_busy_o   (tx_busy_o),
    .cmd_ok_o    (cmd_ok_o),
    .rx_valid_o  (rx_valid_o),
    .rx_data_o   (rx_data_o),
    .overflow_o  (overflow_o),
    .tick_count_o(tick_count_o)
  );

  // Applies one command beat to the behavioral UART and returns the status
  // the block must report for it.
  function automatic uart_status_t advance_uart(input logic [2:0] cmd, input logic ln,
                                                input logic [7:0] data);
    uart_status_t st;
    int unsigned  nxt;
    st    = '0;
    st.ok = 1'b1;
    case (cmd)
      KIND_TICK: begin
        // The transmitter shifts one bit per tick; busy drops on the tick
        // after the last bit has gone out.
        if (u_tx_on) begin
          if (u_tx_word != '0) begin
            u_wire    = u_tx_word[0];
            u_tx_word = u_tx_word >> 1;
          end else begin
            u_tx_on = 1'b0;
          end
        end
        if (u_listen) begin
          if (u_rx_pos == RX_WAIT_START) begin
            if (!ln) begin
              u_rx_pos = '0;
              u_rx_sr  = '0;
            end
          end else if (u_rx_pos >= RX_AWAIT_STOP) begin
            // A good stop bit stores the byte unless only the spare slot is
            // left; a bad one drops the byte without a trace.
            if (ln) begin
              nxt = (u_head + 1) % BUF_DEPTH;
              if (nxt != u_tail) begin
                u_fifo[u_head] = u_rx_sr;
                u_head         = nxt;
              end else begin
                u_ovf = 1'b1;
              end
            end
            u_rx_pos = RX_WAIT_START;
          end else begin
            u_rx_sr  = {ln, u_rx_sr[7:1]};
            u_rx_pos = u_rx_pos + 4'd1;
          end
          u_ticks = u_ticks + 8'd1;
        end
      end
      KIND_SEND: begin
        if (u_tx_on) begin
          st.ok = 1'b0;
        end else begin
          u_tx_word = FRAME_STOP | {1'b0, data, 1'b0};
          u_tx_on   = 1'b1;
          u_drive   = 1'b1;
        end
      end
      KIND_POP: begin
        if (u_head != u_tail) begin
          st.rx_vld  = 1'b1;
          st.rx_byte = u_fifo[u_tail];
          u_tail     = (u_tail + 1) % BUF_DEPTH;
        end
      end
      KIND_PURGE: begin
        u_head = 0;
        u_tail = 0;
      end
      KIND_LISTEN_ON: begin
        u_listen = 1'b1;
        u_drive  = 1'b0;
        u_rx_pos = RX_WAIT_START;
      end
      KIND_LISTEN_OFF: begin
        u_listen = 1'b0;
        u_drive  = 1'b1;
        u_rx_pos = RX_WAIT_START;
      end
      default: begin
      end
    endcase
    st.line_out = u_wire;
    st.drive    = u_drive;
    st.busy     = u_tx_on;
    st.ovf      = u_ovf;
    st.ticks    = u_ticks;
    return st;
  endfunction

  // Scoreboard. Everything is sampled at the rising edge, before any of this
  // edge's nonblocking updates land, so input and output beats are seen
  // exactly as the block sees them. The prediction is pushed before the
  // result check, and the receiver stall is redrawn for the next cycle.
  always @(posedge clk_i) begin : scoreboard
    uart_status_t seen;
    uart_status_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        status_q.push_back(advance_uart(kind_i, line_in_i, tx_byte_i));
      end
      if (out_valid_o && !out_stall_i) begin
        seen = {line_out_o, line_drive_o, tx_busy_o, cmd_ok_o, rx_valid_o, rx_data_o,
                overflow_o, tick_count_o};
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: result beat with nothing expected", $realtime);
          end
        end else begin
          want = status_q.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: mismatch exp line=%b drv=%b busy=%b ok=%b rxv=%b data=%02h ovf=%b ticks=%0d",
                       $realtime, want.line_out, want.drive, want.busy, want.ok, want.rx_vld,
                       want.rx_byte, want.ovf, want.ticks);
              $display("%0t:          got line=%b drv=%b busy=%b ok=%b rxv=%b data=%02h ovf=%b ticks=%0d",
                       $realtime, seen.line_out, seen.drive, seen.busy, seen.ok, seen.rx_vld,
                       seen.rx_byte, seen.ovf, seen.ticks);
            end
          end
        end
      end
      // Watchdog: any beat on either side shows the block is alive.
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
          $display("tb_half_duplex_bit_uart_unit: FAIL");
          $finish;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one command beat and returns at the edge where it is taken. A
  // random number of idle cycles may come first; valid only drops when a gap
  // is actually inserted, so it is never lowered and raised in one step.
  task automatic send_item(input logic [2:0] cmd, input logic ln, input logic [7:0] data);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= cmd;
    line_in_i  <= ln;
    tx_byte_i  <= data;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Holds the sender back until every predicted result has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  // Plays one 8N1 frame onto line_in as ticks: start bit, data LSB first, stop.
  task automatic send_frame(input logic [7:0] data, input logic stop_level);
    send_item(KIND_TICK, 1'b0, 8'($urandom_range(255)));
    for (int b = 0; b < 8; b++) begin
      send_item(KIND_TICK, data[b], 8'($urandom_range(255)));
    end
    send_item(KIND_TICK, stop_level, 8'($urandom_range(255)));
  endtask

  // Command corners: empty pop, the unused kind codes, a tick that must be
  // ignored while idle, a full transmit frame with a refused send in it, a
  // send while listening, and abandoning a partial receive.
  task automatic test_commands();
    send_item(KIND_POP, 1'b0, 8'h00);
    send_item(KIND_RSVD6, 1'b1, 8'hFF);
    send_item(KIND_RSVD7, 1'b0, 8'hFF);
    send_item(KIND_TICK, 1'b0, 8'h00);
    send_item(KIND_SEND, 1'b1, 8'hFF);
    send_item(KIND_SEND, 1'b0, 8'h00);
    // Ten bits go out, and the eleventh tick clears busy.
    for (int i = 0; i < 11; i++) begin
      send_item(KIND_TICK, i[0], 8'h00);
    end
    send_item(KIND_LISTEN_ON, 1'b1, 8'h00);
    send_item(KIND_SEND, 1'b0, 8'h00);
    send_item(KIND_TICK, 1'b0, 8'hFF);
    send_item(KIND_LISTEN_OFF, 1'b1, 8'h00);
    send_item(KIND_PURGE, 1'b0, 8'h00);
    send_item(KIND_POP, 1'b1, 8'h00);
  endtask

  // Well-formed frames with random content, with some bad stop bits, some
  // frames cut short by listen off, sends on top of receiving, and pops.
  task automatic test_rx_frames(input int unsigned count);
    int unsigned pick;
    logic [7:0]  data;
    send_item(KIND_LISTEN_ON, 1'($urandom_range(1)), 8'($urandom_range(255)));
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      data = 8'($urandom_range(255));
      repeat ($urandom_range(2)) send_item(KIND_TICK, 1'b1, 8'($urandom_range(255)));
      if (pick == 0) begin
        send_item(KIND_SEND, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end
      if (pick == 2) begin
        // Listen off after the start bit and four data bits; what follows is
        // just line noise to a freshly armed receiver.
        send_item(KIND_TICK, 1'b0, 8'($urandom_range(255)));
        for (int b = 0; b < 4; b++) send_item(KIND_TICK, data[b], 8'($urandom_range(255)));
        send_item(KIND_LISTEN_OFF, 1'($urandom_range(1)), 8'($urandom_range(255)));
        send_item(KIND_LISTEN_ON, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        send_frame(data, pick != 1);
      end
      if ($urandom_range(2) != 0) begin
        send_item(KIND_POP, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Fills the receive FIFO past its capacity of one less than its depth,
  // then drains it until a pop comes back empty. The overflow flag set here
  // stays up for the rest of the run, purges included.
  task automatic test_fifo_overflow();
    send_item(KIND_LISTEN_ON, 1'b1, 8'h00);
    send_item(KIND_PURGE, 1'b1, 8'h00);
    for (int unsigned n = 0; n < BUF_DEPTH + 1; n++) begin
      send_frame(8'($urandom_range(255)), 1'b1);
    end
    for (int unsigned n = 0; n < BUF_DEPTH; n++) begin
      send_item(KIND_POP, 1'($urandom_range(1)), 8'($urandom_range(255)));
    end
    send_item(KIND_PURGE, 1'b0, 8'h00);
  endtask

  // Unstructured command noise, weighted toward ticks.
  task automatic test_random_mix(input int unsigned count);
    int unsigned r;
    logic [2:0]  cmd;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 55)      cmd = KIND_TICK;
      else if (r < 65) cmd = KIND_SEND;
      else if (r < 75) cmd = KIND_POP;
      else if (r < 80) cmd = KIND_PURGE;
      else if (r < 88) cmd = KIND_LISTEN_ON;
      else if (r < 95) cmd = KIND_LISTEN_OFF;
      else if (r < 97) cmd = KIND_RSVD6;
      else             cmd = KIND_RSVD7;
      send_item(cmd, 1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender mostly busy, receiver stalling often.
    send_idle_pct  = 18;
    recv_stall_pct = 63;
    test_commands();
    test_rx_frames(20);
    wait_drained();

    // Roles swapped: the sender is sparse and the receiver mostly ready.
    send_idle_pct  = 63;
    recv_stall_pct = 18;
    test_rx_frames(15);
    test_fifo_overflow();
    wait_drained();

    // Back-to-back beats on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_mix(400);
    test_rx_frames(10);
    wait_drained();

    // Wait on to catch any stray result beat.
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && status_q.size() == 0) begin
      $display("tb_half_duplex_bit_uart_unit: PASS");
    end else begin
      $display("tb_half_duplex_bit_uart_unit: FAIL");
    end
    $finish;
  end

endmodule
